>>> hdl/segx_pkg.sv
package segx_pkg;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CROSS     = 2'd1,
    ST_COLLINEAR = 2'd2
  } status_e;

  localparam int StatusWidth = 2;

endpackage

>>> hdl/segment_intersection_core.sv
// channel   | signals                                   | direction | handshake
// ----------+-------------------------------------------+-----------+------------------------
// command   | start_i, busy_o, p1..p4 x/y               | in        | start_i && !busy_o
// result    | valid_o, status_o, cross_x_o, cross_y_o   | out       | valid_o, one cycle
//
// one item per cycle; busy_o never rises
// the path from accept to valid_o runs through the seven arithmetic stages, one restoring
// divider stage per quotient bit and the output register
// results cannot be held off, so nothing inside ever stalls
// reset clears only the valid bits of the pipeline
module segment_intersection_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [COORD_WIDTH-1:0]       p1_x_i,
  input  logic signed [COORD_WIDTH-1:0]       p1_y_i,
  input  logic signed [COORD_WIDTH-1:0]       p2_x_i,
  input  logic signed [COORD_WIDTH-1:0]       p2_y_i,
  input  logic signed [COORD_WIDTH-1:0]       p3_x_i,
  input  logic signed [COORD_WIDTH-1:0]       p3_y_i,
  input  logic signed [COORD_WIDTH-1:0]       p4_x_i,
  input  logic signed [COORD_WIDTH-1:0]       p4_y_i,
  output logic                                valid_o,
  output logic [segx_pkg::StatusWidth-1:0]    status_o,
  output logic signed [COORD_WIDTH-1:0]       cross_x_o,
  output logic signed [COORD_WIDTH-1:0]       cross_y_o
);
  import segx_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int AW   = W + 1;
  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int SPW  = 2 * W + 1;
  localparam int ABW  = 2 * W + 2;
  localparam int SW   = 2 * W + 3;
  localparam int DW   = 2 * W + 3;
  localparam int NPW  = 3 * W + 2;
  localparam int NW   = 3 * W + 3;
  localparam int MW   = NW;
  localparam int Lat  = W + 8;

  // stage 1: edge vectors and coordinate products
  logic                   s1_v_q;
  logic signed [W-1:0]    x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [AW-1:0]   a1_q, b1_q, a2_q, b2_q;
  logic signed [PW-1:0]   m21_q, m12_q, m43_q, m34_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= p1_x_i;
    y1_q  <= p1_y_i;
    x2_q  <= p2_x_i;
    y2_q  <= p2_y_i;
    x3_q  <= p3_x_i;
    y3_q  <= p3_y_i;
    x4_q  <= p4_x_i;
    y4_q  <= p4_y_i;
    a1_q  <= AW'(p2_y_i) - AW'(p1_y_i);
    b1_q  <= AW'(p1_x_i) - AW'(p2_x_i);
    a2_q  <= AW'(p4_y_i) - AW'(p3_y_i);
    b2_q  <= AW'(p3_x_i) - AW'(p4_x_i);
    m21_q <= PW'(p2_x_i) * PW'(p1_y_i);
    m12_q <= PW'(p1_x_i) * PW'(p2_y_i);
    m43_q <= PW'(p4_x_i) * PW'(p3_y_i);
    m34_q <= PW'(p3_x_i) * PW'(p4_y_i);
  end

  // stage 2: line offsets and side products
  logic                   s2_v_q;
  logic signed [AW-1:0]   a1_2_q, b1_2_q, a2_2_q, b2_2_q;
  logic signed [CW-1:0]   c1_q, c2_q;
  logic signed [SPW-1:0]  a1x3_q, b1y3_q, a1x4_q, b1y4_q;
  logic signed [SPW-1:0]  a2x1_q, b2y1_q, a2x2_q, b2y2_q;
  logic signed [ABW-1:0]  a1b2_q, a2b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_2_q <= a1_q;
    b1_2_q <= b1_q;
    a2_2_q <= a2_q;
    b2_2_q <= b2_q;
    c1_q   <= CW'(m21_q) - CW'(m12_q);
    c2_q   <= CW'(m43_q) - CW'(m34_q);
    a1x3_q <= SPW'(a1_q) * SPW'(x3_q);
    b1y3_q <= SPW'(b1_q) * SPW'(y3_q);
    a1x4_q <= SPW'(a1_q) * SPW'(x4_q);
    b1y4_q <= SPW'(b1_q) * SPW'(y4_q);
    a2x1_q <= SPW'(a2_q) * SPW'(x1_q);
    b2y1_q <= SPW'(b2_q) * SPW'(y1_q);
    a2x2_q <= SPW'(a2_q) * SPW'(x2_q);
    b2y2_q <= SPW'(b2_q) * SPW'(y2_q);
    a1b2_q <= ABW'(a1_q) * ABW'(b2_q);
    a2b1_q <= ABW'(a2_q) * ABW'(b1_q);
  end

  // stage 3: side values, determinant, numerator products
  logic                   s3_v_q;
  logic signed [SW-1:0]   sd3_q, sd4_q, sd1_q, sd2_q;
  logic signed [DW-1:0]   det_q;
  logic signed [NPW-1:0]  b1c2_q, b2c1_q, a2c1_q, a1c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sd3_q  <= SW'(a1x3_q) + SW'(b1y3_q) + SW'(c1_q);
    sd4_q  <= SW'(a1x4_q) + SW'(b1y4_q) + SW'(c1_q);
    sd1_q  <= SW'(a2x1_q) + SW'(b2y1_q) + SW'(c2_q);
    sd2_q  <= SW'(a2x2_q) + SW'(b2y2_q) + SW'(c2_q);
    det_q  <= DW'(a1b2_q) - DW'(a2b1_q);
    b1c2_q <= NPW'(b1_2_q) * NPW'(c2_q);
    b2c1_q <= NPW'(b2_2_q) * NPW'(c1_q);
    a2c1_q <= NPW'(a2_2_q) * NPW'(c1_q);
    a1c2_q <= NPW'(a1_2_q) * NPW'(c2_q);
  end

  // stage 4: classification, numerators, divisor magnitude
  logic                   s4_v_q;
  status_e                st4_q;
  logic                   dneg4_q;
  logic [DW-1:0]          dmag4_q;
  logic signed [NW-1:0]   nx4_q, ny4_q;
  logic                   same1, same2;
  status_e                st4_d;

  // zero on either end never counts as the same side
  always_comb begin
    same1 = (sd3_q != '0) && (sd4_q != '0) && (sd3_q[SW-1] == sd4_q[SW-1]);
    same2 = (sd1_q != '0) && (sd2_q != '0) && (sd1_q[SW-1] == sd2_q[SW-1]);
    priority if (same1 || same2) begin
      st4_d = ST_NONE;
    end else if (det_q == '0) begin
      st4_d = ST_COLLINEAR;
    end else begin
      st4_d = ST_CROSS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q   <= st4_d;
    dneg4_q <= det_q[DW-1];
    dmag4_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    nx4_q   <= NW'(b1c2_q) - NW'(b2c1_q);
    ny4_q   <= NW'(a2c1_q) - NW'(a1c2_q);
  end

  // stage 5: add half the divisor away from zero
  logic                   s5_v_q;
  status_e                st5_q;
  logic                   qnx5_q, qny5_q;
  logic [DW-1:0]          dmag5_q;
  logic signed [NW:0]     nx5_q, ny5_q;
  logic signed [NW:0]     half_s;

  assign half_s = $signed({{(NW + 1 - DW){1'b0}}, dmag4_q >> 1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st5_q   <= st4_q;
    dmag5_q <= dmag4_q;
    qnx5_q  <= nx4_q[NW-1] ^ dneg4_q;
    qny5_q  <= ny4_q[NW-1] ^ dneg4_q;
    nx5_q   <= nx4_q[NW-1] ? (NW + 1)'(nx4_q) - half_s : (NW + 1)'(nx4_q) + half_s;
    ny5_q   <= ny4_q[NW-1] ? (NW + 1)'(ny4_q) - half_s : (NW + 1)'(ny4_q) + half_s;
  end

  // stage 6: dividend magnitudes
  logic                   s6_v_q;
  status_e                st6_q;
  logic                   qnx6_q, qny6_q;
  logic [DW-1:0]          dmag6_q;
  logic [MW-1:0]          rx6_q, ry6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st6_q   <= st5_q;
    qnx6_q  <= qnx5_q;
    qny6_q  <= qny5_q;
    dmag6_q <= dmag5_q;
    rx6_q   <= nx5_q[NW] ? MW'(-nx5_q) : MW'(nx5_q);
    ry6_q   <= ny5_q[NW] ? MW'(-ny5_q) : MW'(ny5_q);
  end

  // stage 7 feeds divider slot 0: overflow when the quotient reaches 2^W
  logic                   dv_q   [0:W];
  status_e                dst_q  [0:W];
  logic                   dqnx_q [0:W];
  logic                   dqny_q [0:W];
  logic                   dovx_q [0:W];
  logic                   dovy_q [0:W];
  logic [DW-1:0]          dmag_q [0:W];
  logic [MW-1:0]          drx_q  [0:W];
  logic [MW-1:0]          dry_q  [0:W];
  logic [W-1:0]           dqx_q  [0:W];
  logic [W-1:0]           dqy_q  [0:W];
  logic [MW-1:0]          dtop;

  assign dtop = {dmag6_q, {W{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q[0]  <= st6_q;
    dqnx_q[0] <= qnx6_q;
    dqny_q[0] <= qny6_q;
    dovx_q[0] <= rx6_q >= dtop;
    dovy_q[0] <= ry6_q >= dtop;
    dmag_q[0] <= dmag6_q;
    drx_q[0]  <= rx6_q;
    dry_q[0]  <= ry6_q;
    dqx_q[0]  <= '0;
    dqy_q[0]  <= '0;
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int Sh = W - 1 - k;
    logic [MW-1:0] ds;
    logic          bx, by;

    assign ds = MW'({{W{1'b0}}, dmag_q[k]} << Sh);
    assign bx = drx_q[k] >= ds;
    assign by = dry_q[k] >= ds;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dst_q[k+1]  <= dst_q[k];
      dqnx_q[k+1] <= dqnx_q[k];
      dqny_q[k+1] <= dqny_q[k];
      dovx_q[k+1] <= dovx_q[k];
      dovy_q[k+1] <= dovy_q[k];
      dmag_q[k+1] <= dmag_q[k];
      drx_q[k+1]  <= bx ? drx_q[k] - ds : drx_q[k];
      dry_q[k+1]  <= by ? dry_q[k] - ds : dry_q[k];
      dqx_q[k+1]  <= {dqx_q[k][W-2:0], bx};
      dqy_q[k+1]  <= {dqy_q[k][W-2:0], by};
    end
  end

  // output stage: sign, saturation, zero unless crossing
  localparam logic [W-1:0] MaxPos = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MaxNeg = {1'b1, {(W - 1){1'b0}}};

  function automatic logic [W-1:0] sat_q(input logic q_neg, input logic ovf,
                                         input logic [W-1:0] q);
    logic [W-1:0] r;
    if (q_neg) begin
      r = (ovf || (q > MaxNeg)) ? MaxNeg : W'(-q);
    end else begin
      r = (ovf || (q > MaxPos)) ? MaxPos : q;
    end
    return r;
  endfunction

  logic                   out_v_q;
  status_e                out_st_q;
  logic [W-1:0]           out_x_q, out_y_q;
  logic                   is_cross;

  assign is_cross = dst_q[W] == ST_CROSS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    out_st_q <= dst_q[W];
    out_x_q  <= is_cross ? sat_q(dqnx_q[W], dovx_q[W], dqx_q[W]) : '0;
    out_y_q  <= is_cross ? sat_q(dqny_q[W], dovy_q[W], dqy_q[W]) : '0;
  end

  assign busy_o    = 1'b0;
  assign valid_o   = out_v_q;
  assign status_o  = out_st_q;
  assign cross_x_o = $signed(out_x_q);
  assign cross_y_o = $signed(out_y_q);

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Lat valid_o)
    else $error("item lost in pipeline");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##Lat !valid_o)
    else $error("result without item");

  a_zero_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != ST_CROSS)) |-> (cross_x_o == '0 && cross_y_o == '0))
    else $error("coordinates set without crossing");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_NONE || status_o == ST_CROSS || status_o == ST_COLLINEAR))
    else $error("bad status code");

endmodule

>>> tb/sv/segx_checker.sv
`timescale 1ns / 1ps

module segx_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic signed [15:0] p1_x_i,
  input  logic signed [15:0] p1_y_i,
  input  logic signed [15:0] p2_x_i,
  input  logic signed [15:0] p2_y_i,
  input  logic signed [15:0] p3_x_i,
  input  logic signed [15:0] p3_y_i,
  input  logic signed [15:0] p4_x_i,
  input  logic signed [15:0] p4_y_i,
  input  logic               valid_o,
  input  logic [1:0]         status_o,
  input  logic signed [15:0] cross_x_o,
  input  logic signed [15:0] cross_y_o,
  output int                 fail_count,
  output int                 pending,
  output int                 n_none,
  output int                 n_cross,
  output int                 n_coll,
  output int                 n_sat
);
  import segx_pkg::*;

  localparam longint CoordMax = 32767;
  localparam longint CoordMin = -32768;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic logic signed [15:0] rounded_quot(logic signed [127:0] num, longint den);
    logic signed [127:0] off, q, d;
    d   = den;
    off = (den < 0 ? -den : den) / 2;
    num = (num < 0) ? num - off : num + off;
    q   = num / d;
    if (q > CoordMax) q = CoordMax;
    if (q < CoordMin) q = CoordMin;
    return q[15:0];
  endfunction

  function automatic logic on_same_side(longint u, longint v);
    return u != 0 && v != 0 && ((u < 0) == (v < 0));
  endfunction

  function automatic crossing_t predict_crossing(longint x1, longint y1, longint x2,
                                                 longint y2, longint x3, longint y3,
                                                 longint x4, longint y4);
    crossing_t r;
    longint a1, b1, c1, a2, b2, c2, det;
    logic signed [127:0] nx, ny;
    r = '{status: ST_NONE, cx: '0, cy: '0};
    a1 = y2 - y1;
    b1 = x1 - x2;
    c1 = x2 * y1 - x1 * y2;
    if (on_same_side(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1)) return r;
    a2 = y4 - y3;
    b2 = x3 - x4;
    c2 = x4 * y3 - x3 * y4;
    if (on_same_side(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2)) return r;
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      r.status = ST_COLLINEAR;
      return r;
    end
    nx = 128'(signed'(b1)) * 128'(signed'(c2)) - 128'(signed'(b2)) * 128'(signed'(c1));
    ny = 128'(signed'(a2)) * 128'(signed'(c1)) - 128'(signed'(a1)) * 128'(signed'(c2));
    r.status = ST_CROSS;
    r.cx = rounded_quot(nx, det);
    r.cy = rounded_quot(ny, det);
    return r;
  endfunction

  assign pending = crossing_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t e;
    if (!rst_ni) begin
      fail_count <= 0;
      n_none <= 0;
      n_cross <= 0;
      n_coll <= 0;
      n_sat <= 0;
    end else begin
      if (start_i && !busy_o) begin
        e = predict_crossing(p1_x_i, p1_y_i, p2_x_i, p2_y_i, p3_x_i, p3_y_i, p4_x_i, p4_y_i);
        crossing_q.push_back(e);
        case (e.status)
          ST_NONE:      n_none <= n_none + 1;
          ST_CROSS:     n_cross <= n_cross + 1;
          default:      n_coll <= n_coll + 1;
        endcase
        if (e.status == ST_CROSS && (e.cx == 16'sh7fff || e.cx == 16'sh8000 ||
            e.cy == 16'sh7fff || e.cy == 16'sh8000))
          n_sat <= n_sat + 1;
      end
      if (valid_o) begin
        if (crossing_q.size() == 0) begin
          $error("result with no item outstanding: status %0d", status_o);
          fail_count <= fail_count + 1;
        end else begin
          e = crossing_q.pop_front();
          if (status_o !== e.status || cross_x_o !== e.cx || cross_y_o !== e.cy)
            fail_count <= fail_count + 1;
          if (status_o !== e.status)
            $error("status: expected %0d, got %0d", e.status, status_o);
          if (cross_x_o !== e.cx)
            $error("cross_x: expected %0d, got %0d", e.cx, cross_x_o);
          if (cross_y_o !== e.cy)
            $error("cross_y: expected %0d, got %0d", e.cy, cross_y_o);
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 40;
  localparam int RandomItems   = 700;

  logic clk_i, rst_ni, start_i, busy_o, valid_o;
  logic signed [15:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y;
  logic [1:0] status_o;
  logic signed [15:0] cross_x_o, cross_y_o;
  int fail_count, pending, n_none, n_cross, n_coll, n_sat;
  int quiet_cycles;
  int item_count;
  logic no_idle;

  segment_intersection_core #(.COORD_WIDTH(16)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .p1_x_i(p1_x), .p1_y_i(p1_y), .p2_x_i(p2_x), .p2_y_i(p2_y),
    .p3_x_i(p3_x), .p3_y_i(p3_y), .p4_x_i(p4_x), .p4_y_i(p4_y),
    .valid_o, .status_o, .cross_x_o, .cross_y_o
  );

  segx_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .p1_x_i(p1_x), .p1_y_i(p1_y), .p2_x_i(p2_x), .p2_y_i(p2_y),
    .p3_x_i(p3_x), .p3_y_i(p3_y), .p4_x_i(p4_x), .p4_y_i(p4_y),
    .valid_o, .status_o, .cross_x_o, .cross_y_o,
    .fail_count, .pending, .n_none, .n_cross, .n_coll, .n_sat
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // watchdog: counts cycles with nothing accepted on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("segment_intersection_core: mismatch");
      $finish;
    end
  end

  // one item: random idle gaps unless no_idle is set, then hold start until accepted
  task automatic send_item(input logic [15:0] x1, y1, x2, y2, x3, y3, x4, y4);
    logic taken;
    while (!no_idle && $urandom_range(0, 99) < 23) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    {p1_x, p1_y, p2_x, p2_y} = {x1, y1, x2, y2};
    {p3_x, p3_y, p4_x, p4_y} = {x3, y3, x4, y4};
    start_i = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
      @(negedge clk_i);
    end
    item_count++;
  endtask

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 40)) - 16'd20;
      1: return 16'($urandom_range(0, 2000)) - 16'd1000;
      2: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                     : 16'h8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random;
    int kind, m;
    logic [15:0] x1, y1, x2, y2, x3, y3, x4, y4, dx, dy;
    kind = $urandom_range(0, 9);
    m = $urandom_range(0, 3);
    x1 = pick_coord(m); y1 = pick_coord(m);
    x2 = pick_coord(m); y2 = pick_coord(m);
    x3 = pick_coord(m); y3 = pick_coord(m);
    x4 = pick_coord(m); y4 = pick_coord(m);
    if (kind < 5 && m < 3) begin
      // crossing by construction: second segment straddles the first around its midpoint
      dx = x2 - x1; dy = y2 - y1;
      x3 = x1 + {dx[15], dx[15:1]} + dy; y3 = y1 + {dy[15], dy[15:1]} - dx;
      x4 = x1 + {dx[15], dx[15:1]} - dy + 16'(m == 0 ? $urandom_range(0, 3) : 0);
      y4 = y1 + {dy[15], dy[15:1]} + dx;
    end else if (kind == 5) begin
      // overlapping or parallel along the same direction, the far end at times nudged one unit in y
      dx = x2 - x1; dy = y2 - y1;
      x3 = x1 + dx * 16'($urandom_range(0, 2)); y3 = y1 + dy * 16'($urandom_range(0, 2));
      x4 = x3 + dx; y4 = y3 + dy + 16'($urandom_range(0, 1));
    end else if (kind == 6) begin
      // endpoint shared or a degenerate point
      x3 = x2; y3 = y2;
      if ($urandom_range(0, 1)) begin x4 = x3; y4 = y3; end
    end
    send_item(x1, y1, x2, y2, x3, y3, x4, y4);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    no_idle = 1'b0;
    item_count = 0;
    quiet_cycles = 0;
    {p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y} = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed items
    send_item(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(-10, -10, 10, 10, -10, 10, 10, -10);
    send_item(0, 0, 10, 0, 0, 5, 10, 5);
    send_item(0, 0, 10, 0, 5, 0, 15, 0);
    send_item(0, 0, 10, 0, 5, 0, 5, 10);
    send_item(0, 0, 10, 0, 3, 1, 7, 5);
    send_item(0, 0, 3, 1, 0, 1, 3, 0);
    send_item(0, 0, 1, 3, 1, 0, 0, 3);
    send_item(0, 0, 3, 2, 0, 2, 3, 0);
    send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_item(16'h8000, 0, 16'h7fff, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8001, 16'h7fff, 16'h7fff);
    send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7ffe, 16'h8000, 16'h8001, 16'h7fff, 16'h7fff);
    send_item(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'h5555, 16'haaaa, 16'haaaa);
    send_item(0, 0, 4, 4, 4, 4, 8, 0);
    send_item(0, 0, 4, 4, 5, 5, 9, 1);

    // hold off until the pipeline has drained
    start_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);

    for (int i = 0; i < RandomItems; i++) begin
      no_idle = (i >= 300 && i < 420);
      send_random();
    end
    start_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d items: %0d crossing (%0d saturated), %0d apart, %0d collinear",
             item_count, n_cross, n_sat, n_none, n_coll);
    if (fail_count == 0) begin
      $display("segment_intersection_core: match");
    end else begin
      $display("segment_intersection_core: mismatch");
    end
    $finish;
  end

endmodule
